// ===== rtl/mcl_pkg.sv =====
// ----------------------------------------------------------------------------
// mcl_pkg
// Shared types and constants of the motion command limit checker: register
// indexes, error codes, controller states and the serial multiplier digit size.
// ----------------------------------------------------------------------------
package mcl_pkg;

	localparam int FREQ_WIDTH      = 16;
	localparam int DIGIT_WIDTH     = 4;
	localparam int NUM_DIGITS      = FREQ_WIDTH / DIGIT_WIDTH;
	localparam int DIGIT_CNT_WIDTH = $clog2(NUM_DIGITS);
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [FREQ_WIDTH-1:0] FREQ_RESET = 16'd1000;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TICK_FREQUENCY       = 3'd0,
		REG_MAX_VELOCITY         = 3'd1,
		REG_MAX_ACCELERATION     = 3'd2,
		REG_UPPER_POSITION_LIMIT = 3'd3,
		REG_LOWER_POSITION_LIMIT = 3'd4,
		REG_ALLOW_POSITIVE       = 3'd5,
		REG_ALLOW_NEGATIVE       = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_POS_DIR   = 3'd1,
		ERR_NEG_DIR   = 3'd2,
		ERR_VELOCITY  = 3'd3,
		ERR_ACCEL     = 3'd4,
		ERR_UPPER_POS = 3'd5,
		ERR_LOWER_POS = 3'd6
	} err_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF_POS,
		ST_VEL_START,
		ST_VEL_WAIT,
		ST_DIFF_VEL,
		ST_ACC_START,
		ST_ACC_WAIT,
		ST_CHECK,
		ST_DELIVER
	} state_t;

endpackage

// ===== rtl/mcl_if.sv =====
// ----------------------------------------------------------------------------
// mcl_if
// Valid/ready channels of the motion command limit checker: position commands,
// check results and configuration writes.
// ----------------------------------------------------------------------------
interface mcl_cmd_if #(
	parameter int VALUE_WIDTH = 48
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] position_command;

	modport source (output valid, output position_command, input ready);
	modport sink (input valid, input position_command, output ready);
endinterface

interface mcl_res_if #(
	parameter int VALUE_WIDTH = 48
);
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [2:0]                    error_code;
	logic signed [VALUE_WIDTH-1:0] velocity;
	logic signed [VALUE_WIDTH-1:0] acceleration;

	modport source (output valid, output accepted, output error_code, output velocity,
		output acceleration, input ready);
	modport sink (input valid, input accepted, input error_code, input velocity,
		input acceleration, output ready);
endinterface

interface mcl_cfg_if #(
	parameter int VALUE_WIDTH = 48
);
	import mcl_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [VALUE_WIDTH-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mcl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mcl_cfg_regs
// Configuration register file. Every write transaction is taken at once and
// its data is masked to the width of the addressed register.
// ----------------------------------------------------------------------------
module mcl_cfg_regs #(
	parameter int VALUE_WIDTH = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_valid,
	output logic                                 wr_ready,
	input  logic [mcl_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
	input  logic [VALUE_WIDTH-1:0]               wr_data,
	output logic [mcl_pkg::FREQ_WIDTH-1:0]       tick_frequency,
	output logic [VALUE_WIDTH-2:0]               max_velocity,
	output logic [VALUE_WIDTH-2:0]               max_acceleration,
	output logic signed [VALUE_WIDTH-1:0]        upper_position_limit,
	output logic signed [VALUE_WIDTH-1:0]        lower_position_limit,
	output logic                                 allow_positive,
	output logic                                 allow_negative
);
	import mcl_pkg::*;

	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [FREQ_WIDTH-1:0]         tick_frequency_q;
	logic [VALUE_WIDTH-2:0]        max_velocity_q;
	logic [VALUE_WIDTH-2:0]        max_acceleration_q;
	logic [VALUE_WIDTH-1:0]        upper_limit_q;
	logic [VALUE_WIDTH-1:0]        lower_limit_q;
	logic                          allow_positive_q;
	logic                          allow_negative_q;

	assign wr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_frequency_q   <= FREQ_RESET;
			max_velocity_q     <= {(VALUE_WIDTH-1){1'b1}};
			max_acceleration_q <= {(VALUE_WIDTH-1){1'b1}};
			upper_limit_q      <= VALUE_MAX;
			lower_limit_q      <= VALUE_MIN;
			allow_positive_q   <= 1'b1;
			allow_negative_q   <= 1'b1;
		end else if (wr_valid) begin
			unique case (wr_index)
				REG_TICK_FREQUENCY:       tick_frequency_q   <= wr_data[FREQ_WIDTH-1:0];
				REG_MAX_VELOCITY:         max_velocity_q     <= wr_data[VALUE_WIDTH-2:0];
				REG_MAX_ACCELERATION:     max_acceleration_q <= wr_data[VALUE_WIDTH-2:0];
				REG_UPPER_POSITION_LIMIT: upper_limit_q      <= wr_data;
				REG_LOWER_POSITION_LIMIT: lower_limit_q      <= wr_data;
				REG_ALLOW_POSITIVE:       allow_positive_q   <= wr_data[0];
				REG_ALLOW_NEGATIVE:       allow_negative_q   <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign tick_frequency       = tick_frequency_q;
	assign max_velocity         = max_velocity_q;
	assign max_acceleration     = max_acceleration_q;
	assign upper_position_limit = upper_limit_q;
	assign lower_position_limit = lower_limit_q;
	assign allow_positive       = allow_positive_q;
	assign allow_negative       = allow_negative_q;

endmodule

// ===== rtl/mcl_serial_mul.sv =====
// ----------------------------------------------------------------------------
// mcl_serial_mul
// Digit-serial saturating multiplier of a signed value by the unsigned tick
// frequency. The frequency is shifted in one digit per cycle, most significant
// digit first, and the exact product is clamped to the signed range.
// ----------------------------------------------------------------------------
module mcl_serial_mul #(
	parameter int VALUE_WIDTH = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [VALUE_WIDTH-1:0]     operand,
	input  logic [mcl_pkg::FREQ_WIDTH-1:0]    freq,
	output logic                              done,
	output logic signed [VALUE_WIDTH-1:0]     result
);
	import mcl_pkg::*;

	localparam int PROD_WIDTH = VALUE_WIDTH + FREQ_WIDTH;
	localparam int PART_WIDTH = VALUE_WIDTH + DIGIT_WIDTH;
	localparam logic [PROD_WIDTH-1:0] HALF_RANGE = PROD_WIDTH'(1) << (VALUE_WIDTH - 1);
	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic                       busy_q;
	logic                       fin_q;
	logic                       done_q;
	logic [DIGIT_CNT_WIDTH-1:0] cnt_q;
	logic                       neg_q;
	logic [VALUE_WIDTH-1:0]     mag_q;
	logic [FREQ_WIDTH-1:0]      freq_q;
	logic [PROD_WIDTH-1:0]      prod_q;
	logic [VALUE_WIDTH-1:0]     result_q;

	logic [VALUE_WIDTH-1:0]     operand_mag;
	logic [DIGIT_WIDTH-1:0]     digit;
	logic [PART_WIDTH-1:0]      part;
	logic                       overflow;
	logic [VALUE_WIDTH-1:0]     prod_low;

	assign operand_mag = operand[VALUE_WIDTH-1] ? (~operand + 1'b1) : operand;
	assign digit       = freq_q[FREQ_WIDTH-1 -: DIGIT_WIDTH];
	assign part        = PART_WIDTH'(mag_q) * PART_WIDTH'(digit);
	assign overflow    = neg_q ? (prod_q > HALF_RANGE) : (prod_q >= HALF_RANGE);
	assign prod_low    = prod_q[VALUE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIGIT_CNT_WIDTH'(NUM_DIGITS - 1)) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= operand[VALUE_WIDTH-1];
			mag_q  <= operand_mag;
			freq_q <= freq;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= (prod_q << DIGIT_WIDTH) + PROD_WIDTH'(part);
			freq_q <= freq_q << DIGIT_WIDTH;
		end else if (fin_q) begin
			if (overflow) begin
				result_q <= neg_q ? VALUE_MIN : VALUE_MAX;
			end else begin
				result_q <= neg_q ? (~prod_low + 1'b1) : prod_low;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/motion_command_limit_check.sv =====
// ----------------------------------------------------------------------------
// motion_command_limit_check
// Checks one axis position command per servo tick against direction,
// velocity, acceleration and position limits.
// ----------------------------------------------------------------------------
// The cmd channel carries one signed position command per transaction. Each
// command yields exactly one transaction on the res channel with the accept
// flag, the error code and the derived velocity and acceleration. The cfg
// channel writes the limit registers and is always ready; the user must keep
// it written only while no command is in flight, as the block does not enforce it.
// After acceptance a command passes through the position subtract, a first
// pass through the digit-serial multiplier, which takes one frequency digit
// per cycle, the velocity subtract, a second multiplier pass, the check and
// the delivery step; the next command is taken only when these are done.
// The result sits in an output register, so a stalled receiver does not block
// the next command from being taken and worked on; the block waits only when
// a new result is ready while the previous one has not been taken.
// Reset clears the position and velocity history to zero and loads the
// registers with their reset values.
// ----------------------------------------------------------------------------
module motion_command_limit_check #(
	parameter int VALUE_WIDTH = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	mcl_cmd_if.sink   cmd,
	mcl_res_if.source res,
	mcl_cfg_if.sink   cfg
);
	import mcl_pkg::*;

	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	state_t state_q, state_d;

	logic [FREQ_WIDTH-1:0]         tick_frequency;
	logic [VALUE_WIDTH-2:0]        max_velocity;
	logic [VALUE_WIDTH-2:0]        max_acceleration;
	logic signed [VALUE_WIDTH-1:0] upper_position_limit;
	logic signed [VALUE_WIDTH-1:0] lower_position_limit;
	logic                          allow_positive;
	logic                          allow_negative;

	logic signed [VALUE_WIDTH-1:0] pos_q;
	logic signed [VALUE_WIDTH-1:0] diff_q;
	logic signed [VALUE_WIDTH-1:0] vel_q;
	logic signed [VALUE_WIDTH-1:0] acc_q;
	logic signed [VALUE_WIDTH-1:0] prev_pos_q;
	logic signed [VALUE_WIDTH-1:0] prev_vel_q;
	err_code_t                     code_q;
	err_code_t                     check_code;

	logic                          res_valid_q;
	logic                          res_accepted_q;
	err_code_t                     res_code_q;
	logic signed [VALUE_WIDTH-1:0] res_vel_q;
	logic signed [VALUE_WIDTH-1:0] res_acc_q;

	logic                          cmd_ready;
	logic                          mul_start;
	logic                          mul_done;
	logic signed [VALUE_WIDTH-1:0] mul_result;
	logic                          res_load;

	logic signed [VALUE_WIDTH-1:0] sub_a;
	logic signed [VALUE_WIDTH-1:0] sub_b;
	logic [VALUE_WIDTH:0]          sub_wide;
	logic [VALUE_WIDTH-1:0]        sub_sat;

	logic                          vel_pos;
	logic                          vel_neg;
	logic [VALUE_WIDTH-1:0]        vel_mag;
	logic [VALUE_WIDTH-1:0]        acc_mag;

	mcl_cfg_regs #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_cfg_regs (
		.clk                 (clk),
		.arst_n              (arst_n),
		.wr_valid            (cfg.valid),
		.wr_ready            (cfg.ready),
		.wr_index            (cfg.index),
		.wr_data             (cfg.data),
		.tick_frequency      (tick_frequency),
		.max_velocity        (max_velocity),
		.max_acceleration    (max_acceleration),
		.upper_position_limit(upper_position_limit),
		.lower_position_limit(lower_position_limit),
		.allow_positive      (allow_positive),
		.allow_negative      (allow_negative)
	);

	mcl_serial_mul #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_serial_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.operand(diff_q),
		.freq   (tick_frequency),
		.done   (mul_done),
		.result (mul_result)
	);

	assign sub_a    = (state_q == ST_DIFF_VEL) ? vel_q : pos_q;
	assign sub_b    = (state_q == ST_DIFF_VEL) ? prev_vel_q : prev_pos_q;
	assign sub_wide = {sub_a[VALUE_WIDTH-1], sub_a} - {sub_b[VALUE_WIDTH-1], sub_b};
	assign sub_sat  = (sub_wide[VALUE_WIDTH] != sub_wide[VALUE_WIDTH-1]) ?
		(sub_wide[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX) : sub_wide[VALUE_WIDTH-1:0];

	assign vel_neg = vel_q[VALUE_WIDTH-1];
	assign vel_pos = !vel_q[VALUE_WIDTH-1] && (vel_q != '0);
	assign vel_mag = vel_neg ? (~vel_q + 1'b1) : vel_q;
	assign acc_mag = acc_q[VALUE_WIDTH-1] ? (~acc_q + 1'b1) : acc_q;

	always_comb begin
		if (vel_pos && !allow_positive) begin
			check_code = ERR_POS_DIR;
		end else if (vel_neg && !allow_negative) begin
			check_code = ERR_NEG_DIR;
		end else if (vel_mag > {1'b0, max_velocity}) begin
			check_code = ERR_VELOCITY;
		end else if (acc_mag > {1'b0, max_acceleration}) begin
			check_code = ERR_ACCEL;
		end else if ((pos_q > upper_position_limit) && vel_pos) begin
			check_code = ERR_UPPER_POS;
		end else if ((pos_q < lower_position_limit) && vel_neg) begin
			check_code = ERR_LOWER_POS;
		end else begin
			check_code = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mul_start = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_DIFF_POS;
				end
			end
			ST_DIFF_POS:  state_d = ST_VEL_START;
			ST_VEL_START: begin
				mul_start = 1'b1;
				state_d   = ST_VEL_WAIT;
			end
			ST_VEL_WAIT: begin
				if (mul_done) begin
					state_d = ST_DIFF_VEL;
				end
			end
			ST_DIFF_VEL:  state_d = ST_ACC_START;
			ST_ACC_START: begin
				mul_start = 1'b1;
				state_d   = ST_ACC_WAIT;
			end
			ST_ACC_WAIT: begin
				if (mul_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:     state_d = ST_DELIVER;
			ST_DELIVER: begin
				if (!res_valid_q || res.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd.valid) begin
			pos_q <= cmd.position_command;
		end
		if (state_q == ST_DIFF_POS || state_q == ST_DIFF_VEL) begin
			diff_q <= sub_sat;
		end
		if (state_q == ST_VEL_WAIT && mul_done) begin
			vel_q <= mul_result;
		end
		if (state_q == ST_ACC_WAIT && mul_done) begin
			acc_q <= mul_result;
		end
		if (state_q == ST_CHECK) begin
			code_q <= check_code;
		end
		if (res_load) begin
			res_accepted_q <= (code_q == ERR_NONE);
			res_code_q     <= code_q;
			res_vel_q      <= vel_q;
			res_acc_q      <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q  <= '0;
			prev_vel_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
				if (code_q == ERR_NONE) begin
					prev_pos_q <= pos_q;
					prev_vel_q <= vel_q;
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd.ready        = cmd_ready;
	assign res.valid        = res_valid_q;
	assign res.accepted     = res_accepted_q;
	assign res.error_code   = res_code_q;
	assign res.velocity     = res_vel_q;
	assign res.acceleration = res_acc_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the motion command limit checker. A predictor in this file
// derives velocity and acceleration from each position command it sends,
// runs the direction, velocity, acceleration and position checks, and keeps
// its own copy of the history and of the limit registers. Every result
// transaction is compared field by field with the oldest prediction.
// Directed commands cover the extremes and every error code; random phases
// then vary all registers, with bursty commands and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

	import mcl_pkg::*;

	localparam int VALUE_WIDTH    = 48;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 25;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_COMMANDS = 150;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [79:0] wide_t;

	localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [79:0] RATE_LIMIT_MAX = (80'd1 << (VALUE_WIDTH-1)) - 80'd1;

	typedef struct {
		logic      accepted;
		err_code_t error_code;
		value_t    velocity;
		value_t    acceleration;
	} verdict_t;

	typedef struct {
		logic [VALUE_WIDTH-1:0] freq;
		logic [VALUE_WIDTH-1:0] max_velocity;
		logic [VALUE_WIDTH-1:0] max_acceleration;
		logic [VALUE_WIDTH-1:0] upper;
		logic [VALUE_WIDTH-1:0] lower;
		logic [VALUE_WIDTH-1:0] allow_positive;
		logic [VALUE_WIDTH-1:0] allow_negative;
	} limit_setting_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mcl_cmd_if #(.VALUE_WIDTH(VALUE_WIDTH)) cmd ();
	mcl_res_if #(.VALUE_WIDTH(VALUE_WIDTH)) res ();
	mcl_cfg_if #(.VALUE_WIDTH(VALUE_WIDTH)) cfg ();

	motion_command_limit_check #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.res   (res),
		.cfg   (cfg)
	);

	always #5 clk = ~clk;

	logic [FREQ_WIDTH-1:0]  freq_hz          = FREQ_RESET;
	logic [VALUE_WIDTH-2:0] velocity_limit   = '1;
	logic [VALUE_WIDTH-2:0] accel_limit      = '1;
	value_t                 upper_limit      = VALUE_MAX;
	value_t                 lower_limit      = VALUE_MIN;
	logic                   positive_enabled = 1'b1;
	logic                   negative_enabled = 1'b1;
	value_t                 last_position    = '0;
	value_t                 last_velocity    = '0;

	verdict_t    pending_verdicts[$];
	int          failures     = 0;
	int          idle_cycles  = 0;
	int          burst_left   = 0;
	logic [79:0] step_size    = 80'd1;
	logic        hold_request = 1'b0;
	int          hold_left    = 0;
	int          stall_mode   = 0;
	int          stall_left   = 0;

	function automatic value_t clamp_value(input wide_t x);
		wide_t hi;
		wide_t lo;
		hi = VALUE_MAX;
		lo = VALUE_MIN;
		if (x > hi) return VALUE_MAX;
		if (x < lo) return VALUE_MIN;
		return x[VALUE_WIDTH-1:0];
	endfunction

	function automatic value_t saturating_diff(input value_t a, input value_t b);
		wide_t wa;
		wide_t wb;
		wa = a;
		wb = b;
		return clamp_value(wa - wb);
	endfunction

	function automatic value_t scale_by_rate(input value_t d);
		wide_t wd;
		wide_t wf;
		wd = d;
		wf = {64'd0, freq_hz};
		return clamp_value(wd * wf);
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] magnitude(input value_t v);
		logic signed [VALUE_WIDTH:0] w;
		w = v;
		if (w < 0) w = -w;
		return w[VALUE_WIDTH-1:0];
	endfunction

	task automatic judge_command(input value_t pos);
		value_t   vel;
		value_t   acc;
		verdict_t v;
		vel = scale_by_rate(saturating_diff(pos, last_position));
		acc = scale_by_rate(saturating_diff(vel, last_velocity));
		v.error_code = ERR_NONE;
		if (vel > 0 && !positive_enabled) v.error_code = ERR_POS_DIR;
		else if (vel < 0 && !negative_enabled) v.error_code = ERR_NEG_DIR;
		else if (magnitude(vel) > velocity_limit) v.error_code = ERR_VELOCITY;
		else if (magnitude(acc) > accel_limit) v.error_code = ERR_ACCEL;
		else if (pos > upper_limit && vel > 0) v.error_code = ERR_UPPER_POS;
		else if (pos < lower_limit && vel < 0) v.error_code = ERR_LOWER_POS;
		v.accepted = (v.error_code == ERR_NONE);
		v.velocity = vel;
		v.acceleration = acc;
		if (v.accepted) begin
			last_position = pos;
			last_velocity = vel;
		end
		pending_verdicts.push_back(v);
	endtask

	task automatic store_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [VALUE_WIDTH-1:0] word);
		case (idx)
			REG_TICK_FREQUENCY: begin
				freq_hz = word[FREQ_WIDTH-1:0];
			end
			REG_MAX_VELOCITY: begin
				velocity_limit = word[VALUE_WIDTH-2:0];
			end
			REG_MAX_ACCELERATION: begin
				accel_limit = word[VALUE_WIDTH-2:0];
			end
			REG_UPPER_POSITION_LIMIT: begin
				upper_limit = word;
			end
			REG_LOWER_POSITION_LIMIT: begin
				lower_limit = word;
			end
			REG_ALLOW_POSITIVE: begin
				positive_enabled = word[0];
			end
			REG_ALLOW_NEGATIVE: begin
				negative_enabled = word[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_command(input value_t pos);
		if (burst_left == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
		end
		burst_left--;
		cmd.valid <= 1'b1;
		cmd.position_command <= pos;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		judge_command(pos);
		@(negedge clk);
	endtask

	task automatic drain_results();
		cmd.valid <= 1'b0;
		burst_left = 0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [VALUE_WIDTH-1:0] word);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= word;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		store_register(idx, word);
		@(negedge clk);
	endtask

	task automatic apply_setting(input limit_setting_t s);
		drain_results();
		write_register(REG_TICK_FREQUENCY, s.freq);
		write_register(REG_MAX_VELOCITY, s.max_velocity);
		write_register(REG_MAX_ACCELERATION, s.max_acceleration);
		write_register(REG_UPPER_POSITION_LIMIT, s.upper);
		write_register(REG_LOWER_POSITION_LIMIT, s.lower);
		write_register(REG_ALLOW_POSITIVE, s.allow_positive);
		write_register(REG_ALLOW_NEGATIVE, s.allow_negative);
		write_register(REG_UNMAPPED, VALUE_WIDTH'({$urandom(), $urandom()}));
		cfg.valid <= 1'b0;
	endtask

	function automatic limit_setting_t permissive_setting(input logic [FREQ_WIDTH-1:0] f);
		limit_setting_t s;
		s.freq = f;
		s.max_velocity = RATE_LIMIT_MAX[VALUE_WIDTH-1:0];
		s.max_acceleration = RATE_LIMIT_MAX[VALUE_WIDTH-1:0];
		s.upper = VALUE_MAX;
		s.lower = VALUE_MIN;
		s.allow_positive = 1;
		s.allow_negative = 1;
		return s;
	endfunction

	function automatic wide_t random_offset(input logic [79:0] span);
		logic [79:0] r;
		r = {16'd0, $urandom(), $urandom()};
		return $signed(r % (2 * span + 1)) - $signed(span);
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_rate_limit(input logic [79:0] span);
		logic [79:0] x;
		case ($urandom_range(0, 5))
			0: x = RATE_LIMIT_MAX;
			1: x = 80'd0;
			2: x = {16'd0, $urandom(), $urandom()} & RATE_LIMIT_MAX;
			default: x = span * $urandom_range(1, 4) / 2;
		endcase
		if (x > RATE_LIMIT_MAX) x = RATE_LIMIT_MAX;
		return x[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_position_limit(input value_t extreme);
		logic [63:0] r;
		wide_t       base;
		r = {$urandom(), $urandom()};
		base = last_position;
		case ($urandom_range(0, 3))
			0: return extreme;
			1: return r[VALUE_WIDTH-1:0];
			default: return clamp_value(base + random_offset(step_size * 8));
		endcase
	endfunction

	task automatic choose_setting(output limit_setting_t s);
		logic [79:0] rate_span;
		logic [63:0] r;
		step_size = 80'd1 << $urandom_range(0, 36);
		case ($urandom_range(0, 4))
			0: s.freq = 1;
			1: s.freq = 65535;
			2: s.freq = FREQ_RESET;
			default: s.freq = $urandom_range(1, 65535);
		endcase
		rate_span = step_size * s.freq[FREQ_WIDTH-1:0];
		s.max_velocity = pick_rate_limit(rate_span);
		s.max_acceleration = pick_rate_limit(rate_span * s.freq[FREQ_WIDTH-1:0] * 2);
		s.upper = pick_position_limit(VALUE_MAX);
		s.lower = pick_position_limit(VALUE_MIN);
		s.allow_positive = ($urandom_range(0, 3) != 0);
		s.allow_negative = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 3) == 0) begin
			r = {$urandom(), $urandom()};
			s.freq[VALUE_WIDTH-1:FREQ_WIDTH] = r[31:0];
			s.max_velocity[VALUE_WIDTH-1] = 1'b1;
			s.max_acceleration[VALUE_WIDTH-1] = r[40];
			s.allow_positive[VALUE_WIDTH-1:1] = r[VALUE_WIDTH-2:0];
			s.allow_negative[VALUE_WIDTH-1:1] = ~r[VALUE_WIDTH-2:0];
		end
	endtask

	task automatic next_position(output value_t pos);
		logic [63:0] r;
		wide_t       base;
		r = {$urandom(), $urandom()};
		base = last_position;
		case ($urandom_range(0, 15))
			11: pos = last_position;
			12: pos = r[VALUE_WIDTH-1:0];
			13: pos = r[0] ? VALUE_MAX : VALUE_MIN;
			14: begin
				base = upper_limit;
				pos = clamp_value(base + random_offset(step_size));
			end
			15: begin
				base = lower_limit;
				pos = clamp_value(base + random_offset(step_size));
			end
			default: pos = clamp_value(base + random_offset(step_size));
		endcase
	endtask

	task automatic test_reset_values();
		send_command(48'sd0);
		send_command(48'sd1);
		send_command(VALUE_MAX);
		send_command(VALUE_MIN);
		send_command(-48'sd1);
	endtask

	task automatic test_zero_frequency();
		limit_setting_t s;
		s = permissive_setting(16'd0);
		s.upper = -48'sd100;
		s.lower = 48'sd100;
		apply_setting(s);
		send_command(48'sd12345);
		send_command(VALUE_MIN);
		send_command(VALUE_MAX);
	endtask

	task automatic test_direction_enables();
		limit_setting_t s;
		s = permissive_setting(16'd1);
		s.allow_positive = 0;
		apply_setting(s);
		send_command(48'sd0);
		send_command(48'sd10);
		send_command(48'sd0);
		send_command(-48'sd7);
		s.allow_positive = 1;
		s.allow_negative = 0;
		apply_setting(s);
		send_command(-48'sd20);
		send_command(48'sd5);
		send_command(48'sd5);
	endtask

	task automatic test_limit_checks();
		limit_setting_t s;
		s = permissive_setting(16'd1);
		s.max_velocity = 100;
		s.max_acceleration = 45;
		s.upper = 48'sd50;
		s.lower = 48'sd30;
		apply_setting(s);
		send_command(48'sd105);
		send_command(48'sd25);
		send_command(48'sd130);
		send_command(48'sd45);
		send_command(48'sd65);
		send_command(48'sd45);
		send_command(48'sd25);
		// Crossed limits: a position lies above the upper and below the lower limit, and the velocity sign picks the error.
		s.upper = -48'sd10;
		s.lower = 48'sd100;
		apply_setting(s);
		send_command(48'sd46);
		send_command(48'sd44);
	endtask

	task automatic test_backpressure();
		value_t pos;
		apply_setting(permissive_setting(FREQ_RESET));
		step_size = 80'd1 << 10;
		hold_request = 1'b1;
		burst_left = 1000;
		repeat (12) begin
			next_position(pos);
			send_command(pos);
		end
		drain_results();
	endtask

	task automatic test_random_commands();
		limit_setting_t s;
		value_t         pos;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				apply_setting(permissive_setting(16'd65535));
				step_size = 80'd1 << 20;
			end else begin
				choose_setting(s);
				apply_setting(s);
			end
			repeat (PHASE_COMMANDS) begin
				next_position(pos);
				send_command(pos);
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		if (hold_left != 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= ($urandom_range(0, 3) != 0);
				default: res.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		verdict_t due;
		if (arst_n && res.valid && res.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result transaction with no command outstanding");
				failures++;
			end else begin
				due = pending_verdicts.pop_front();
				if (res.accepted !== due.accepted) begin
					$error("accepted: expected %0d, got %0d", due.accepted, res.accepted);
					failures++;
				end
				if (res.error_code !== due.error_code) begin
					$error("error_code: expected %0d, got %0d", due.error_code,
						res.error_code);
					failures++;
				end
				if (res.velocity !== due.velocity) begin
					$error("velocity: expected %0d, got %0d", due.velocity, res.velocity);
					failures++;
				end
				if (res.acceleration !== due.acceleration) begin
					$error("acceleration: expected %0d, got %0d", due.acceleration,
						res.acceleration);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.position_command = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_zero_frequency();
		test_direction_enables();
		test_limit_checks();
		test_backpressure();
		test_random_commands();

		drain_results();
		if (failures == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
